[rtl/ddodo_pkg.sv]
`default_nettype none
package ddodo_pkg;

  // Tunable parameters of the arithmetic
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STEPS  = 16;
  localparam int POS_FRAC_BITS = 12;

  // Field and datapath widths
  localparam int CNT_W     = 32;
  localparam int DELTA_W   = 16;
  localparam int SUM_W     = DELTA_W + 1;
  localparam int REG_W     = 24;
  localparam int HEAD_W    = 24;
  localparam int HDG_OUT_W = 16;
  localparam int POS_W     = 32;
  localparam int TRAV_W    = 24;
  localparam int DTH_W     = 26;
  localparam int CS_W      = 32;
  localparam int TURN_W    = 32;
  localparam int Z_W       = TURN_W + 1;
  localparam int MA_W      = CS_W + 1;
  localparam int MB_W      = REG_W + 1;
  localparam int PROD_W    = MA_W + MB_W;
  localparam int IT_W      = $clog2(CORDIC_STEPS);
  localparam int ATAN_N    = 24;
  localparam int ATAN_IDX_W = $clog2(ATAN_N);

  // Rounding shifts
  localparam int TRAV_SH = 25 - POS_FRAC_BITS;
  localparam int TURN_SH = 16;
  localparam int CS_SH   = 30;

  localparam logic signed [CS_W-1:0]    CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [DELTA_W-1:0] DELTA_LIMIT = 16'sd32767;

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MM_PER_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_PER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_NEGATE    = 2'd2;
  localparam logic [REG_W-1:0] MM_PER_COUNT_RST   = 24'd113821;
  localparam logic [REG_W-1:0] TURN_PER_COUNT_RST = 24'd11263900;

  // Micro-operations of the datapath
  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_DELTA = 4'd1,
    OP_MULT  = 4'd2,
    OP_RNDT  = 4'd3,
    OP_MULH  = 4'd4,
    OP_RNDH  = 4'd5,
    OP_MID   = 4'd6,
    OP_ITER  = 4'd7,
    OP_MULC  = 4'd8,
    OP_RNDX  = 4'd9,
    OP_MULS  = 4'd10,
    OP_RNDY  = 4'd11,
    OP_HEAD  = 4'd12,
    OP_DONE  = 4'd13
  } op_t;

  // Jump conditions
  typedef enum logic [1:0] {
    C_NONE  = 2'd0,
    C_NOREF = 2'd1,
    C_ITER  = 2'd2,
    C_OBUSY = 2'd3
  } cond_t;

  localparam int PC_W = 4;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } cw_t;

  typedef struct packed {
    logic noref;
    logic iter_more;
  } dp_stat_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_DELTA = 4'd0;
  localparam logic [PC_W-1:0] PC_MULT  = 4'd1;
  localparam logic [PC_W-1:0] PC_RNDT  = 4'd2;
  localparam logic [PC_W-1:0] PC_MULH  = 4'd3;
  localparam logic [PC_W-1:0] PC_RNDH  = 4'd4;
  localparam logic [PC_W-1:0] PC_MID   = 4'd5;
  localparam logic [PC_W-1:0] PC_ITER  = 4'd6;
  localparam logic [PC_W-1:0] PC_MULC  = 4'd7;
  localparam logic [PC_W-1:0] PC_RNDX  = 4'd8;
  localparam logic [PC_W-1:0] PC_MULS  = 4'd9;
  localparam logic [PC_W-1:0] PC_RNDY  = 4'd10;
  localparam logic [PC_W-1:0] PC_HEAD  = 4'd11;
  localparam logic [PC_W-1:0] PC_DONE  = 4'd12;

  // Control store: one word per program step
  function automatic cw_t ucode(input logic [PC_W-1:0] pc);
    cw_t cw;
    cw = '{op: OP_DONE, cond: C_OBUSY, target: PC_DONE};
    case (pc)
      PC_DELTA: cw = '{op: OP_DELTA, cond: C_NOREF, target: PC_DONE};
      PC_MULT:  cw = '{op: OP_MULT,  cond: C_NONE,  target: PC_DELTA};
      PC_RNDT:  cw = '{op: OP_RNDT,  cond: C_NONE,  target: PC_DELTA};
      PC_MULH:  cw = '{op: OP_MULH,  cond: C_NONE,  target: PC_DELTA};
      PC_RNDH:  cw = '{op: OP_RNDH,  cond: C_NONE,  target: PC_DELTA};
      PC_MID:   cw = '{op: OP_MID,   cond: C_NONE,  target: PC_DELTA};
      PC_ITER:  cw = '{op: OP_ITER,  cond: C_ITER,  target: PC_ITER};
      PC_MULC:  cw = '{op: OP_MULC,  cond: C_NONE,  target: PC_DELTA};
      PC_RNDX:  cw = '{op: OP_RNDX,  cond: C_NONE,  target: PC_DELTA};
      PC_MULS:  cw = '{op: OP_MULS,  cond: C_NONE,  target: PC_DELTA};
      PC_RNDY:  cw = '{op: OP_RNDY,  cond: C_NONE,  target: PC_DELTA};
      PC_HEAD:  cw = '{op: OP_HEAD,  cond: C_NONE,  target: PC_DELTA};
      PC_DONE:  cw = '{op: OP_DONE,  cond: C_OBUSY, target: PC_DONE};
      default:  cw = '{op: OP_DONE,  cond: C_OBUSY, target: PC_DONE};
    endcase
    return cw;
  endfunction

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [TURN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] i);
    logic [TURN_W-1:0] a;
    a = '0;
    case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

[rtl/differential_drive_odometry_core.sv]
`default_nettype none
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// in_      | input     | in_valid/in_stall  | left_count, right_count
// out_     | output    | out_valid/out_stall| pos_x, pos_y, heading, step_travel,
//          |           |                    | delta_clipped
// cfg_     | input     | cfg_we             | cfg_index, cfg_wdata (no read-back)
//
// After acceptance a request runs DELTA, MULT, RNDT, MULH, RNDH, MID, the ITER loop,
// MULC, RNDX, MULS, RNDY, HEAD and DONE; a new request is taken only back in idle.
// The CORDIC loop runs one micro-rotation per cycle on the shared datapath.
// The first request after reset only latches the counts and jumps from DELTA to DONE.
// Reset (rst_n low, synchronous) zeroes the pose and restores the register defaults.
// A stalled result sits in the output register while the next request is accepted.
module differential_drive_odometry_core import ddodo_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [CNT_W-1:0] in_left_count,
  input  wire logic signed [CNT_W-1:0] in_right_count,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [POS_W-1:0]      out_pos_x,
  output logic signed [POS_W-1:0]      out_pos_y,
  output logic [HDG_OUT_W-1:0]         out_heading,
  output logic signed [TRAV_W-1:0]     out_step_travel,
  output logic                         out_delta_clipped,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [REG_W-1:0]        cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } seq_state_t;

  seq_state_t       state_r;
  logic [PC_W-1:0]  pc_r;
  logic [CNT_W-1:0] left_r, right_r;
  logic [REG_W-1:0] mm_r, turn_r;
  logic             neg_r;
  logic             out_valid_r;

  cw_t              cw;
  dp_stat_t         stat;
  logic             out_busy;
  logic             take_jump;
  logic             finish;

  logic signed [POS_W-1:0]  dp_x, dp_y;
  logic [HEAD_W-1:0]        dp_head;
  logic signed [TRAV_W-1:0] dp_trav;
  logic                     dp_clip;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_r   <= MM_PER_COUNT_RST;
      turn_r <= TURN_PER_COUNT_RST;
      neg_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MM_PER_COUNT:   mm_r   <= cfg_wdata;
        CFG_TURN_PER_COUNT: turn_r <= cfg_wdata;
        CFG_TURN_NEGATE:    neg_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Fetch control word; idle issues no operation
  always_comb begin
    if (state_r == S_RUN) begin
      cw = ucode(pc_r);
    end else begin
      cw = '{op: OP_NOP, cond: C_NONE, target: PC_DELTA};
    end
  end

  // Evaluate jump condition
  assign out_busy = out_valid_r & out_stall;
  always_comb begin
    case (cw.cond)
      C_NONE:  take_jump = 1'b0;
      C_NOREF: take_jump = stat.noref;
      C_ITER:  take_jump = stat.iter_more;
      C_OBUSY: take_jump = out_busy;
      default: take_jump = 1'b0;
    endcase
  end
  assign finish = (cw.op == OP_DONE) & ~out_busy;

  // Sequencer: accept a request, step the program, return to idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= PC_DELTA;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_RUN;
            pc_r    <= PC_DELTA;
          end
        end
        S_RUN: begin
          if (finish) begin
            state_r <= S_IDLE;
          end else if (take_jump) begin
            pc_r <= cw.target;
          end else begin
            pc_r <= pc_r + PC_W'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Hold the accepted counts for the run
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      left_r  <= in_left_count;
      right_r <= in_right_count;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  ddodo_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cw               (cw),
    .left_count       (left_r),
    .right_count      (right_r),
    .mm_per_count     (mm_r),
    .turn_per_count   (turn_r),
    .turn_sign_negate (neg_r),
    .stat             (stat),
    .pos_x            (dp_x),
    .pos_y            (dp_y),
    .acc_heading      (dp_head),
    .step_travel      (dp_trav),
    .delta_clipped    (dp_clip)
  );

  // Output register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_pos_x         <= dp_x;
      out_pos_y         <= dp_y;
      out_heading       <= dp_head[HEAD_W-1 -: HDG_OUT_W];
      out_step_travel   <= dp_trav;
      out_delta_clipped <= dp_clip;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[rtl/ddodo_dp.sv]
`default_nettype none
module ddodo_dp import ddodo_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cw_t                      cw,
  input  wire logic [CNT_W-1:0]         left_count,
  input  wire logic [CNT_W-1:0]         right_count,
  input  wire logic [REG_W-1:0]         mm_per_count,
  input  wire logic [REG_W-1:0]         turn_per_count,
  input  wire logic                     turn_sign_negate,
  output dp_stat_t                      stat,
  output logic signed [POS_W-1:0]       pos_x,
  output logic signed [POS_W-1:0]       pos_y,
  output logic [HEAD_W-1:0]             acc_heading,
  output logic signed [TRAV_W-1:0]      step_travel,
  output logic                          delta_clipped
);

  // Odometry state
  logic [CNT_W-1:0]         last_l_r, last_r_r;
  logic signed [POS_W-1:0]  ax_r, ay_r;
  logic [HEAD_W-1:0]        ah_r;
  logic                     have_r;

  // Work registers
  logic signed [DELTA_W-1:0] dl_r, dr_r;
  logic                      clip_r;
  logic signed [TRAV_W-1:0]  trav_r;
  logic signed [DTH_W-1:0]   dth_r;
  logic signed [CS_W-1:0]    cx_r, cy_r;
  logic signed [Z_W-1:0]     cz_r;
  logic                      flip_r;
  logic [IT_W-1:0]           it_r;
  logic signed [PROD_W-1:0]  prod_r;

  // Combinational values
  logic [DELTA_W:0]          dl_c, dr_c;
  logic signed [SUM_W-1:0]   sum_c, diff_c, diffn_c;
  logic signed [MA_W-1:0]    ma_c;
  logic signed [MB_W-1:0]    mb_c;
  logic signed [PROD_W-1:0]  rnd_c;
  logic [DTH_W:0]            dth_t;
  logic [HEAD_W-1:0]         mid_nxt;
  logic [TURN_W-1:0]         t_nxt;
  logic signed [CS_W-1:0]    sx_c, sy_c;
  logic [Z_W-1:0]            at_c;
  logic [POS_W:0]            sum_x, sum_y;
  logic signed [POS_W-1:0]   sat_x, sat_y;
  logic                      trav_fits;

  // Wrapped count difference saturated to the delta limit: {clip, value}
  function automatic logic [DELTA_W:0] sat_delta(input logic [CNT_W-1:0] now,
                                                 input logic [CNT_W-1:0] prev);
    logic signed [CNT_W-1:0] d;
    logic                    hi, lo;
    d  = $signed(now - prev);
    hi = d > CNT_W'(DELTA_LIMIT);
    lo = d < -CNT_W'(DELTA_LIMIT);
    if (hi) return {1'b1, DELTA_LIMIT};
    if (lo) return {1'b1, -DELTA_LIMIT};
    return {1'b0, d[DELTA_W-1:0]};
  endfunction

  // Shift right by sh, rounding half away from zero
  function automatic logic signed [PROD_W-1:0] round_sh(input logic signed [PROD_W-1:0] v,
                                                        input int sh);
    logic [PROD_W:0] half;
    logic [PROD_W:0] t;
    half = (PROD_W+1)'(1) << (sh - 1);
    t    = {v[PROD_W-1], v} + half - {{PROD_W{1'b0}}, v[PROD_W-1]};
    return PROD_W'($signed(t) >>> sh);
  endfunction

  // Count differences and their sum and turn difference
  always_comb begin
    dl_c    = sat_delta(left_count, last_l_r);
    dr_c    = sat_delta(right_count, last_r_r);
    sum_c   = SUM_W'(dl_r) + SUM_W'(dr_r);
    diff_c  = SUM_W'(dr_r) - SUM_W'(dl_r);
    diffn_c = turn_sign_negate ? -diff_c : diff_c;
  end

  // Select multiplier operands
  always_comb begin
    ma_c = '0;
    mb_c = '0;
    case (cw.op)
      OP_MULT: begin
        ma_c = MA_W'(sum_c);
        mb_c = $signed({1'b0, mm_per_count});
      end
      OP_MULH: begin
        ma_c = MA_W'(diffn_c);
        mb_c = $signed({1'b0, turn_per_count});
      end
      OP_MULC: begin
        ma_c = flip_r ? -MA_W'(cx_r) : MA_W'(cx_r);
        mb_c = MB_W'(trav_r);
      end
      OP_MULS: begin
        ma_c = flip_r ? -MA_W'(cy_r) : MA_W'(cy_r);
        mb_c = MB_W'(trav_r);
      end
      default: begin
        ma_c = '0;
        mb_c = '0;
      end
    endcase
  end

  // Rounding of the product, shift chosen by the step
  always_comb begin
    case (cw.op)
      OP_RNDT: rnd_c = round_sh(prod_r, TRAV_SH);
      OP_RNDH: rnd_c = round_sh(prod_r, TURN_SH);
      default: rnd_c = round_sh(prod_r, CS_SH);
    endcase
    trav_fits = (rnd_c[PROD_W-1:TRAV_W-1] == '0) || (rnd_c[PROD_W-1:TRAV_W-1] == '1);
  end

  // Midpoint heading and its angle for the CORDIC; the quadrant fold is in OP_MID
  always_comb begin
    dth_t   = {dth_r[DTH_W-1], dth_r} + {{DTH_W{1'b0}}, ~dth_r[DTH_W-1]};
    mid_nxt = ah_r + dth_t[HEAD_W:1];
    t_nxt   = {mid_nxt[HEAD_W-1 -: ANGLE_BITS], {(TURN_W-ANGLE_BITS){1'b0}}};
  end

  // CORDIC micro-rotation terms
  always_comb begin
    sx_c = cx_r >>> it_r;
    sy_c = cy_r >>> it_r;
    at_c = Z_W'(atan_turn(ATAN_IDX_W'(it_r)));
  end

  // Position accumulate with saturation
  always_comb begin
    sum_x = {ax_r[POS_W-1], ax_r} + rnd_c[POS_W:0];
    sum_y = {ay_r[POS_W-1], ay_r} + rnd_c[POS_W:0];
    if (sum_x[POS_W] != sum_x[POS_W-1]) begin
      sat_x = sum_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      sat_x = $signed(sum_x[POS_W-1:0]);
    end
    if (sum_y[POS_W] != sum_y[POS_W-1]) begin
      sat_y = sum_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      sat_y = $signed(sum_y[POS_W-1:0]);
    end
  end

  // Pose and reference state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_l_r <= '0;
      last_r_r <= '0;
      ax_r     <= '0;
      ay_r     <= '0;
      ah_r     <= '0;
      have_r   <= 1'b0;
    end else begin
      case (cw.op)
        OP_DELTA: begin
          last_l_r <= left_count;
          last_r_r <= right_count;
          have_r   <= 1'b1;
        end
        OP_RNDX: ax_r <= sat_x;
        OP_RNDY: ay_r <= sat_y;
        OP_HEAD: ah_r <= ah_r + dth_r[HEAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Work registers: one operation per step
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_DELTA: begin
        dl_r   <= $signed(dl_c[DELTA_W-1:0]);
        dr_r   <= $signed(dr_c[DELTA_W-1:0]);
        clip_r <= have_r & (dl_c[DELTA_W] | dr_c[DELTA_W]);
        trav_r <= '0;
      end
      OP_MULT, OP_MULH, OP_MULC, OP_MULS: prod_r <= ma_c * mb_c;
      OP_RNDT: begin
        if (trav_fits) begin
          trav_r <= rnd_c[TRAV_W-1:0];
        end else begin
          trav_r <= rnd_c[PROD_W-1] ? {1'b1, {(TRAV_W-1){1'b0}}}
                                    : {1'b0, {(TRAV_W-1){1'b1}}};
        end
      end
      OP_RNDH: dth_r <= rnd_c[DTH_W-1:0];
      OP_MID: begin
        flip_r <= t_nxt[TURN_W-1] ^ t_nxt[TURN_W-2];
        cz_r   <= $signed({t_nxt[TURN_W-1] ^ t_nxt[TURN_W-2] ^ t_nxt[TURN_W-1],
                           t_nxt[TURN_W-1] ^ t_nxt[TURN_W-2] ^ t_nxt[TURN_W-1],
                           t_nxt[TURN_W-2:0]});
        cx_r   <= CORDIC_GAIN;
        cy_r   <= '0;
        it_r   <= '0;
      end
      OP_ITER: begin
        if (!cz_r[Z_W-1]) begin
          cx_r <= cx_r - sy_c;
          cy_r <= cy_r + sx_c;
          cz_r <= cz_r - $signed(at_c);
        end else begin
          cx_r <= cx_r + sy_c;
          cy_r <= cy_r - sx_c;
          cz_r <= cz_r + $signed(at_c);
        end
        it_r <= it_r + IT_W'(1);
      end
      default: ;
    endcase
  end

  // Status to the sequencer and results
  assign stat.noref     = ~have_r;
  assign stat.iter_more = (it_r != IT_W'(CORDIC_STEPS - 1));
  assign pos_x          = ax_r;
  assign pos_y          = ay_r;
  assign acc_heading    = ah_r;
  assign step_travel    = trav_r;
  assign delta_clipped  = clip_r;

endmodule
`default_nettype wire

[tb/sv/differential_drive_odometry_core_tb.sv]
module differential_drive_odometry_core_tb;
  import ddodo_pkg::*;

  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 40;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int SPRINT_STEPS    = 280;
  localparam int RANDOM_STEPS    = 260;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam logic [REG_W-1:0]     SCALE_MAX    = '1;

  localparam longint WHEEL_LIMIT = 32767;
  localparam longint TRAVEL_HIGH = 8388607;
  localparam longint TRAVEL_LOW  = -8388608;
  localparam longint GAIN_Q30    = 652032874;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [HDG_OUT_W-1:0]     heading;
    logic signed [TRAV_W-1:0] step_travel;
    logic                     delta_clipped;
  } pose_report_t;

  // DUT connections
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [CNT_W-1:0]        in_left_count = '0;
  logic [CNT_W-1:0]        in_right_count = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [POS_W-1:0] out_pos_x;
  logic signed [POS_W-1:0] out_pos_y;
  logic [HDG_OUT_W-1:0]    out_heading;
  logic signed [TRAV_W-1:0] out_step_travel;
  logic                    out_delta_clipped;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [REG_W-1:0]        cfg_wdata = '0;

  // Pose estimate and register copy kept by the testbench
  logic [CNT_W-1:0]        est_prev_left;
  logic [CNT_W-1:0]        est_prev_right;
  logic signed [POS_W-1:0] est_x;
  logic signed [POS_W-1:0] est_y;
  logic [HEAD_W-1:0]       est_heading;
  bit                      est_anchored;
  logic [REG_W-1:0]        set_mm_scale;
  logic [REG_W-1:0]        set_turn_scale;
  bit                      set_turn_flip;

  longint atan_step_q32 [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  pose_report_t pending_poses [$];
  int error_count = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_off_req = 0;
  int hold_left = 0;
  int pattern_left = 0;
  int stall_pct = 0;

  differential_drive_odometry_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_left_count     (in_left_count),
    .in_right_count    (in_right_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_heading       (out_heading),
    .out_step_travel   (out_step_travel),
    .out_delta_clipped (out_delta_clipped),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("differential_drive_odometry_core_tb failed");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR: %s", msg);
  endtask

  // Round half away from zero after a right shift
  function automatic longint round_half_away(input longint v, input int sh);
    longint half;
    half = (sh > 0) ? (longint'(1) <<< (sh - 1)) : 0;
    if (v < 0)
      return -((-v + half) >>> sh);
    return (v + half) >>> sh;
  endfunction

  function automatic logic signed [POS_W-1:0] saturate_pos(input longint v);
    if (v > longint'(32'sh7FFF_FFFF))
      return 32'sh7FFF_FFFF;
    if (v < -longint'(32'sh7FFF_FFFF) - 1)
      return 32'sh8000_0000;
    return POS_W'(v);
  endfunction

  // Wrapped count difference, limited to the wheel delta range
  function automatic longint wheel_delta(input logic [CNT_W-1:0] now_cnt,
                                         input logic [CNT_W-1:0] prev_cnt,
                                         inout bit clipped);
    logic signed [CNT_W-1:0] d;
    longint s;
    d = now_cnt - prev_cnt;
    s = longint'(d);
    if (s > WHEEL_LIMIT) begin
      s = WHEEL_LIMIT;
      clipped = 1'b1;
    end else if (s < -WHEEL_LIMIT) begin
      s = -WHEEL_LIMIT;
      clipped = 1'b1;
    end
    return s;
  endfunction

  // Rotation-mode CORDIC with quadrant fold; results carry 30 fraction bits
  function automatic void cordic_sin_cos(input logic [ANGLE_BITS-1:0] angle,
                                         output longint cos_q30,
                                         output longint sin_q30);
    logic [31:0] t;
    bit flip;
    longint x, y, z, nx;
    t = 32'(angle) << (32 - ANGLE_BITS);
    flip = (t[31:30] == 2'b01) || (t[31:30] == 2'b10);
    if (flip)
      t = t - 32'h8000_0000;
    z = longint'(signed'(t));
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_step_q32[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_step_q32[i];
      end
      x = nx;
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endfunction

  // Advance the pose estimate by one sample and return the report it gives
  function automatic pose_report_t advance_odometry(input logic [CNT_W-1:0] left,
                                                    input logic [CNT_W-1:0] right);
    pose_report_t r;
    bit clipped;
    longint dl, dr, diff, travel, dth, cs, sn;
    logic [HEAD_W-1:0] mid;
    clipped = 1'b0;
    travel = 0;
    if (!est_anchored) begin
      est_anchored = 1'b1;
    end else begin
      dl = wheel_delta(left, est_prev_left, clipped);
      dr = wheel_delta(right, est_prev_right, clipped);
      travel = round_half_away((dl + dr) * longint'(set_mm_scale), 25 - POS_FRAC_BITS);
      if (travel > TRAVEL_HIGH)
        travel = TRAVEL_HIGH;
      else if (travel < TRAVEL_LOW)
        travel = TRAVEL_LOW;
      diff = dr - dl;
      if (set_turn_flip)
        diff = -diff;
      dth = round_half_away(diff * longint'(set_turn_scale), 16);
      mid = est_heading + HEAD_W'(round_half_away(dth, 1));
      cordic_sin_cos(mid[HEAD_W-1 -: ANGLE_BITS], cs, sn);
      est_x = saturate_pos(longint'(est_x) + round_half_away(travel * cs, 30));
      est_y = saturate_pos(longint'(est_y) + round_half_away(travel * sn, 30));
      est_heading = est_heading + HEAD_W'(dth);
    end
    est_prev_left = left;
    est_prev_right = right;
    r.pos_x = est_x;
    r.pos_y = est_y;
    r.heading = est_heading[HEAD_W-1 -: HDG_OUT_W];
    r.step_travel = TRAV_W'(travel);
    r.delta_clipped = clipped;
    return r;
  endfunction

  task automatic reset_estimate();
    est_prev_left = '0;
    est_prev_right = '0;
    est_x = '0;
    est_y = '0;
    est_heading = '0;
    est_anchored = 1'b0;
    set_mm_scale = MM_PER_COUNT_RST;
    set_turn_scale = TURN_PER_COUNT_RST;
    set_turn_flip = 1'b0;
  endtask

  // Offer one request; bursts of random length separated by random gaps
  task automatic send_counts(input logic [CNT_W-1:0] left, input logic [CNT_W-1:0] right);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_left_count <= left;
    in_right_count <= right;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_poses.push_back(advance_odometry(left, right));
    burst_left--;
  endtask

  task automatic send_move(input longint dl, input longint dr);
    send_counts(est_prev_left + CNT_W'(dl), est_prev_right + CNT_W'(dr));
  endtask

  // Spin in place toward a heading; assumes full turn scale and no negation
  task automatic turn_to(input logic [HEAD_W-1:0] target);
    logic signed [HEAD_W-1:0] offset;
    longint diff, dl;
    offset = target - est_heading;
    diff = longint'(offset) / 256;
    dl = -(diff / 2);
    send_move(dl, diff + dl);
  endtask

  // Drop valid, let every outstanding result drain, then let the core settle
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_poses.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [REG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_MM_PER_COUNT:   set_mm_scale = data;
      CFG_TURN_PER_COUNT: set_turn_scale = data;
      CFG_TURN_NEGATE:    set_turn_flip = data[0];
      default: ;
    endcase
  endtask

  task automatic configure_odometry(input logic [REG_W-1:0] mm, input logic [REG_W-1:0] turn,
                                    input bit flip, input bit stray_write);
    wait_idle();
    if (stray_write)
      write_register(CFG_UNMAPPED, REG_W'($urandom));
    write_register(CFG_MM_PER_COUNT, mm);
    write_register(CFG_TURN_PER_COUNT, turn);
    write_register(CFG_TURN_NEGATE, {$urandom_range(0, 1) ? 23'h7FFFFF : 23'h0, flip});
    cfg_we <= 1'b0;
  endtask

  // First sample only latches the reference; next ones run on reset registers
  task automatic test_reference_sample();
    send_counts(32'h8000_0000, 32'h7FFF_FFFF);
    send_move(100, 300);
    send_move(-5, 7);
  endtask

  // Delta limits, saturation flag and 32-bit wraparound of the counts
  task automatic test_count_limits();
    send_move(32767, 32767);
    send_move(-32767, -32767);
    send_move(32768, 0);
    send_move(0, -32768);
    send_move(0, 0);
    send_move(-2147483648, 5);
    send_counts(32'h7FFF_FFF0, 32'hFFFF_FFF8);
    send_counts(32'h8000_0010, 32'h0000_0008);
    send_counts(32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_turn_sign();
    configure_odometry(MM_PER_COUNT_RST, TURN_PER_COUNT_RST, 1'b1, 1'b0);
    send_move(-5000, 5000);
    configure_odometry(MM_PER_COUNT_RST, TURN_PER_COUNT_RST, 1'b0, 1'b0);
    send_move(-5000, 5000);
  endtask

  // Zero and full scales, travel saturation, half-way rounding, unmapped index
  task automatic test_register_extremes();
    configure_odometry('0, '0, 1'b0, 1'b1);
    send_move(1000, -500);
    configure_odometry(SCALE_MAX, SCALE_MAX, 1'b1, 1'b0);
    send_move(32767, -32767);
    send_move(32767, 32767);
    send_move(-32767, -32767);
    configure_odometry(24'd1, 24'd1, 1'b0, 1'b1);
    send_move(2048, 2048);
    send_move(-2048, -2048);
    send_move(-16384, 16384);
  endtask

  // Hold the result channel off so the core backs up into its input
  task automatic test_output_backpressure();
    configure_odometry(MM_PER_COUNT_RST, TURN_PER_COUNT_RST, 1'b0, 1'b0);
    hold_off_req = HOLD_OFF_CYCLES;
    repeat (12)
      send_move(longint'($urandom_range(0, 8000)) - 4000,
                longint'($urandom_range(0, 8000)) - 4000);
  endtask

  // Drive flat out east, then south, until both positions hit their limits
  task automatic test_position_saturation();
    longint r;
    configure_odometry(SCALE_MAX, SCALE_MAX, 1'b0, 1'b0);
    turn_to(24'h000000);
    repeat (SPRINT_STEPS) begin
      r = longint'($urandom_range(2100, 32767));
      send_move(r, r);
    end
    turn_to(24'hC00000);
    repeat (SPRINT_STEPS) begin
      r = longint'($urandom_range(2100, 32767));
      send_move(r, r);
    end
  endtask

  // Segments of cruising, spinning, limit jumps and noise under varied settings
  task automatic test_random_motion();
    int made, seg_len, mag, roll;
    longint base_l, base_r, dl, dr, s;
    made = 0;
    while (made < RANDOM_STEPS) begin
      case ($urandom_range(0, 4))
        0: configure_odometry(MM_PER_COUNT_RST, TURN_PER_COUNT_RST,
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        1: configure_odometry(REG_W'($urandom), REG_W'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        2: configure_odometry(SCALE_MAX, REG_W'($urandom), 1'($urandom_range(0, 1)), 1'b0);
        3: configure_odometry(REG_W'($urandom_range(0, 4095)), SCALE_MAX,
                              1'($urandom_range(0, 1)), 1'b0);
        default: configure_odometry('0, '0, 1'($urandom_range(0, 1)), 1'b0);
      endcase
      case ($urandom_range(0, 2))
        0: mag = 64;
        1: mag = 4096;
        default: mag = 32767;
      endcase
      base_l = longint'($urandom_range(0, 2 * mag)) - mag;
      base_r = longint'($urandom_range(0, 2 * mag)) - mag;
      seg_len = $urandom_range(10, 40);
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          send_move(base_l + longint'($urandom_range(0, 16)) - 8,
                    base_r + longint'($urandom_range(0, 16)) - 8);
        end else if (roll < 82) begin
          s = longint'($urandom_range(0, 65534)) - 32767;
          send_move(-s, s);
        end else if (roll < 92) begin
          case ($urandom_range(0, 5))
            0: dl = 32767;
            1: dl = 32768;
            2: dl = -32767;
            3: dl = -32768;
            4: dl = 65535;
            default: dl = -2147483648;
          endcase
          dr = $urandom_range(0, 1) ? -dl : longint'($urandom_range(0, 200)) - 100;
          if ($urandom_range(0, 1))
            send_move(dl, dr);
          else
            send_move(dr, dl);
        end else begin
          send_counts($urandom, $urandom);
        end
        made++;
      end
    end
  endtask

  // Result channel: stall on a pattern of changing density, or hold off on request
  always @(posedge clk) begin
    if (hold_off_req != 0) begin
      hold_left = hold_off_req;
      hold_off_req = 0;
    end
    if (pattern_left == 0) begin
      pattern_left = $urandom_range(16, 160);
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2: stall_pct = 25;
        3: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    pattern_left--;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare each accepted result with the oldest outstanding pose
  always @(posedge clk) begin
    pose_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_poses.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing outstanding", results_seen));
      end else begin
        want = pending_poses.pop_front();
        if (out_pos_x !== want.pos_x)
          report_error($sformatf("result %0d pos_x got %0d want %0d",
                                 results_seen, out_pos_x, want.pos_x));
        if (out_pos_y !== want.pos_y)
          report_error($sformatf("result %0d pos_y got %0d want %0d",
                                 results_seen, out_pos_y, want.pos_y));
        if (out_heading !== want.heading)
          report_error($sformatf("result %0d heading got %0d want %0d",
                                 results_seen, out_heading, want.heading));
        if (out_step_travel !== want.step_travel)
          report_error($sformatf("result %0d step_travel got %0d want %0d",
                                 results_seen, out_step_travel, want.step_travel));
        if (out_delta_clipped !== want.delta_clipped)
          report_error($sformatf("result %0d delta_clipped got %0b want %0b",
                                 results_seen, out_delta_clipped, want.delta_clipped));
      end
      results_seen++;
    end
  end

  initial begin
    reset_estimate();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reference_sample();
    test_count_limits();
    test_turn_sign();
    test_register_extremes();
    test_output_backpressure();
    test_position_saturation();
    test_random_motion();
    wait_idle();
    if (pending_poses.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_poses.size()));
    if (error_count == 0)
      $display("differential_drive_odometry_core_tb passed");
    else
      $display("differential_drive_odometry_core_tb failed");
    $finish;
  end

endmodule
